// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/tsspl_pkg.sv -----
package tsspl_pkg;

  // Geometry and fixed constants
  localparam int unsigned BIN_COUNT_DEF = 60;
  localparam int unsigned BACK_OFFSET   = 21;
  localparam int unsigned SYNC_SECOND   = 3;
  localparam int unsigned SECOND_SKEW   = 2;
  localparam int unsigned SCORE_W       = 8;
  localparam int unsigned PADDR_W       = 3;
  localparam int unsigned PDATA_W       = 32;

  localparam logic [SCORE_W-1:0] LOCK_THR_RST = 8'd12;

  // Register index codes (word index taken from paddr)
  localparam logic REG_LOCK_THR = 1'b0;

  // Score step sizes
  localparam logic [2:0] AMT_NONE = 3'd0;
  localparam logic [2:0] AMT_HIT  = 3'd1;
  localparam logic [2:0] AMT_MISS = 3'd2;
  localparam logic [2:0] AMT_SYNC = 3'd6;

  typedef enum logic [1:0] {
    TC_UNDEF,
    TC_SHORT,
    TC_LONG,
    TC_SYNC
  } tick_class_e;

  // Order in which the touched bins are visited during an update
  typedef enum logic [1:0] {
    SLOT_CUR,
    SLOT_PREV,
    SLOT_NEXT,
    SLOT_BACK
  } bin_slot_e;

  typedef struct packed {
    logic       inc;
    logic [2:0] amt;
  } bin_delta_t;

  // Control from the sequencer to the scan unit
  typedef struct packed {
    logic clear;
    logic sample;
  } scan_ctrl_t;

  // Score change for one bin slot under a given tick class
  function automatic bin_delta_t bin_delta(tick_class_e cls, bin_slot_e slot);
    bin_delta_t d;
    d.inc = 1'b0;
    d.amt = AMT_MISS;
    case (cls)
      TC_SYNC: begin
        if (slot == SLOT_CUR) begin
          d.inc = 1'b1;
          d.amt = AMT_SYNC;
        end
      end
      TC_SHORT: begin
        case (slot)
          SLOT_PREV: begin
            d.inc = 1'b1;
            d.amt = AMT_HIT;
          end
          SLOT_NEXT: d.amt = AMT_NONE;
          default:   d.amt = AMT_MISS;
        endcase
      end
      TC_LONG: begin
        case (slot)
          SLOT_BACK: begin
            d.inc = 1'b1;
            d.amt = AMT_HIT;
          end
          SLOT_NEXT: d.amt = AMT_NONE;
          default:   d.amt = AMT_MISS;
        endcase
      end
      default: begin
        if (slot == SLOT_NEXT) begin
          d.amt = AMT_NONE;
        end
      end
    endcase
    return d;
  endfunction

  // Saturating apply of a delta to an 8-bit score
  function automatic logic [SCORE_W-1:0] sat_apply(logic [SCORE_W-1:0] v, bin_delta_t d);
    logic [SCORE_W:0]   sum;
    logic [SCORE_W-1:0] amt_w;
    logic [SCORE_W-1:0] res;
    amt_w = {{(SCORE_W-3){1'b0}}, d.amt};
    sum   = {1'b0, v} + {1'b0, amt_w};
    if (d.inc) begin
      res = sum[SCORE_W] ? {SCORE_W{1'b1}} : sum[SCORE_W-1:0];
    end else begin
      res = (v > amt_w) ? (v - amt_w) : '0;
    end
    return res;
  endfunction

endpackage

// ----- rtl/tsspl_bin_mem.sv -----
module tsspl_bin_mem #(
  parameter int unsigned DEPTH = tsspl_pkg::BIN_COUNT_DEF,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned DW    = tsspl_pkg::SCORE_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [DW-1:0]    rd_data_q;
  logic             rd_vld_q;

  // Storage array and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // Per-entry written flags; an unwritten bin reads as zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ----- rtl/tsspl_scan.sv -----
module tsspl_scan #(
  parameter int unsigned IDX_W = $clog2(tsspl_pkg::BIN_COUNT_DEF)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tsspl_pkg::scan_ctrl_t         ctrl_i,
  input  logic [IDX_W-1:0]              idx_i,
  input  logic [tsspl_pkg::SCORE_W-1:0] score_i,
  output logic [tsspl_pkg::SCORE_W-1:0] best_score_o,
  output logic [tsspl_pkg::SCORE_W-1:0] runner_score_o,
  output logic [IDX_W-1:0]              best_index_o
);

  logic [tsspl_pkg::SCORE_W-1:0] best_q, best_d;
  logic [tsspl_pkg::SCORE_W-1:0] runner_q, runner_d;
  logic [IDX_W-1:0]              bidx_q, bidx_d;

  // Running max and second max; an equal later score only lifts the runner-up
  always_comb begin
    best_d   = best_q;
    runner_d = runner_q;
    bidx_d   = bidx_q;
    if (ctrl_i.clear) begin
      best_d   = '0;
      runner_d = '0;
      bidx_d   = '0;
    end else if (ctrl_i.sample) begin
      if (score_i > best_q) begin
        runner_d = best_q;
        best_d   = score_i;
        bidx_d   = idx_i;
      end else if (score_i > runner_q) begin
        runner_d = score_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q   <= '0;
      runner_q <= '0;
      bidx_q   <= '0;
    end else begin
      best_q   <= best_d;
      runner_q <= runner_d;
      bidx_q   <= bidx_d;
    end
  end

  assign best_score_o   = best_q;
  assign runner_score_o = runner_q;
  assign best_index_o   = bidx_q;

endmodule

// ----- rtl/time_signal_second_phase_lock_core.sv -----
// Second-phase lock for a once-per-second time signal.
// Input channel: one classified tick per transfer (tick_class_i), valid/stall.
// Output channel: one result per tick (locked, second of minute, sync position,
// lock margin), valid/stall, held in an output register.
// Config: APB-style port; margin threshold at byte address 0. The user must write
// it only while no tick is in flight; the block itself does not enforce this.
// Update: four bin reads (current, previous, next, back slot), each write-back
// in the cycle after its read, then the result is loaded into the output
// register. A rescan, when triggered, reads all BIN_COUNT bins through the
// single memory read port, one per cycle, before that load.
// Throughput: one tick at a time; in_stall_o is high from transfer until the
// result is loaded into the output register. A new tick is taken while that
// result still waits for the receiver.
// When the receiver stalls, the result holds and the block waits to load the
// next one until the held result is taken.
// Reset: all score bins read as zero (per-bin written flags), phase, best and
// runner-up scores and best index clear, the margin threshold returns to 12.
module time_signal_second_phase_lock_core #(
  parameter int unsigned BIN_COUNT = tsspl_pkg::BIN_COUNT_DEF,
  parameter int unsigned IDX_W     = $clog2(BIN_COUNT)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tick input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        tick_class_i,
  // result output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              locked_o,
  output logic [IDX_W-1:0]                  second_of_minute_o,
  output logic [IDX_W-1:0]                  sync_position_o,
  output logic [tsspl_pkg::SCORE_W-1:0]     lock_margin_o,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tsspl_pkg::PADDR_W-1:0]     paddr,
  input  logic [tsspl_pkg::PDATA_W-1:0]     pwdata,
  output logic [tsspl_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready
);

  localparam int unsigned SW    = tsspl_pkg::SCORE_W;
  localparam int unsigned CNT_W = $clog2(BIN_COUNT + 1);
  localparam int unsigned SEC_W = IDX_W + 2;

  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(BIN_COUNT - 1);
  localparam logic [IDX_W-1:0] BACK_L    = IDX_W'(tsspl_pkg::BACK_OFFSET);
  localparam logic [IDX_W-1:0] BACK_WRAP = IDX_W'(BIN_COUNT - tsspl_pkg::BACK_OFFSET);
  localparam logic [IDX_W-1:0] SYNC_SEC  = IDX_W'(tsspl_pkg::SYNC_SECOND);
  localparam logic [CNT_W-1:0] CNT_END   = CNT_W'(BIN_COUNT);
  localparam logic [SEC_W-1:0] SEC_BASE  = SEC_W'(2 * BIN_COUNT - tsspl_pkg::SECOND_SKEW);
  localparam logic [SEC_W-1:0] SEC_ONE   = SEC_W'(BIN_COUNT);
  localparam logic [SEC_W-1:0] SEC_TWO   = SEC_W'(2 * BIN_COUNT);

  localparam logic [2:0] STEP_LAST = 3'd4;

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]               state_q;
  logic [2:0]               step_q;
  logic [CNT_W-1:0]         scan_cnt_q;
  logic                     rd_pend_q;
  tsspl_pkg::bin_slot_e     rd_slot_q;
  logic [IDX_W-1:0]         rd_idx_q;
  tsspl_pkg::tick_class_e   cls_q;
  logic [IDX_W-1:0]         phase_q;
  logic [SW-1:0]            thr_q;
  logic                     out_valid_q;
  logic                     locked_q;
  logic [IDX_W-1:0]         second_q;
  logic [IDX_W-1:0]         sync_pos_q;
  logic [SW-1:0]            margin_q;

  logic [IDX_W-1:0]         prev_w, next_w, back_w;
  logic                     rd_en, wr_en;
  logic [IDX_W-1:0]         rd_addr, wr_addr;
  logic [SW-1:0]            rd_data, wr_data;
  tsspl_pkg::scan_ctrl_t    scan_ctrl;
  logic [SW-1:0]            best_score, runner_score, margin_w;
  logic [IDX_W-1:0]         best_idx;
  logic                     trig_w, lock_w, out_load, in_xfer, cfg_wr;

  // Second of minute from phase and best index, modulo BIN_COUNT
  function automatic logic [IDX_W-1:0] sec_of(logic [IDX_W-1:0] ph, logic [IDX_W-1:0] bi);
    logic [SEC_W-1:0] s;
    s = SEC_BASE + {2'b00, ph} - {2'b00, bi};
    if (s >= SEC_TWO) begin
      s = s - SEC_TWO;
    end else if (s >= SEC_ONE) begin
      s = s - SEC_ONE;
    end
    return s[IDX_W-1:0];
  endfunction

  // Bin address for an update slot
  function automatic logic [IDX_W-1:0] slot_addr(tsspl_pkg::bin_slot_e slot,
                                                 logic [IDX_W-1:0] cur,
                                                 logic [IDX_W-1:0] prv,
                                                 logic [IDX_W-1:0] nxt,
                                                 logic [IDX_W-1:0] bck);
    logic [IDX_W-1:0] a;
    case (slot)
      tsspl_pkg::SLOT_CUR:  a = cur;
      tsspl_pkg::SLOT_PREV: a = prv;
      tsspl_pkg::SLOT_NEXT: a = nxt;
      default:              a = bck;
    endcase
    return a;
  endfunction

  // Neighbor bins of the current phase
  assign prev_w = (phase_q == '0) ? IDX_LAST : phase_q - 1'b1;
  assign next_w = (phase_q == IDX_LAST) ? '0 : phase_q + 1'b1;
  assign back_w = (phase_q >= BACK_L) ? phase_q - BACK_L : phase_q + BACK_WRAP;

  // Lock margin and rescan trigger (old best values, advanced phase)
  assign margin_w = (best_score >= runner_score) ? best_score - runner_score : '0;
  assign lock_w   = (margin_w >= thr_q);
  assign trig_w   = (margin_w <= thr_q) || (lock_w && (sec_of(next_w, best_idx) == SYNC_SEC));

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // Memory port control: update read-modify-write, then rescan sweep
  always_comb begin
    rd_en            = 1'b0;
    rd_addr          = '0;
    wr_en            = 1'b0;
    wr_addr          = slot_addr(rd_slot_q, phase_q, prev_w, next_w, back_w);
    wr_data          = tsspl_pkg::sat_apply(rd_data, tsspl_pkg::bin_delta(cls_q, rd_slot_q));
    scan_ctrl.clear  = 1'b0;
    scan_ctrl.sample = 1'b0;
    case (state_q)
      ST_UPD: begin
        if (step_q != STEP_LAST) begin
          rd_en   = 1'b1;
          rd_addr = slot_addr(tsspl_pkg::bin_slot_e'(step_q[1:0]),
                              phase_q, prev_w, next_w, back_w);
        end
        wr_en           = rd_pend_q;
        scan_ctrl.clear = (step_q == STEP_LAST) && trig_w;
      end
      ST_SCAN: begin
        if (scan_cnt_q != CNT_END) begin
          rd_en   = 1'b1;
          rd_addr = scan_cnt_q[IDX_W-1:0];
        end
        scan_ctrl.sample = rd_pend_q;
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      scan_cnt_q  <= '0;
      rd_pend_q   <= 1'b0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= rd_en;
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            step_q  <= '0;
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          step_q <= step_q + 1'b1;
          if (step_q == STEP_LAST) begin
            phase_q    <= next_w;
            scan_cnt_q <= '0;
            state_q    <= trig_w ? ST_SCAN : ST_DONE;
          end
        end
        ST_SCAN: begin
          if (scan_cnt_q != CNT_END) begin
            scan_cnt_q <= scan_cnt_q + 1'b1;
          end
          if (rd_pend_q && (rd_idx_q == IDX_LAST)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      // Output register handshake
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_slot_q <= tsspl_pkg::bin_slot_e'(step_q[1:0]);
    rd_idx_q  <= scan_cnt_q[IDX_W-1:0];
    if (in_xfer) begin
      cls_q <= tsspl_pkg::tick_class_e'(tick_class_i);
    end
    if (out_load) begin
      locked_q   <= lock_w;
      second_q   <= lock_w ? sec_of(phase_q, best_idx) : '0;
      sync_pos_q <= best_idx;
      margin_q   <= margin_w;
    end
  end

  // Configuration register
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= tsspl_pkg::LOCK_THR_RST;
    end else if (cfg_wr && (paddr[tsspl_pkg::PADDR_W-1] == tsspl_pkg::REG_LOCK_THR)) begin
      thr_q <= pwdata[SW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[tsspl_pkg::PADDR_W-1] == tsspl_pkg::REG_LOCK_THR) ?
                  tsspl_pkg::PDATA_W'(thr_q) : '0;

  // Score memory
  tsspl_bin_mem #(
    .DEPTH (BIN_COUNT),
    .AW    (IDX_W),
    .DW    (SW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // Best / runner-up tracker
  tsspl_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (scan_ctrl),
    .idx_i          (rd_idx_q),
    .score_i        (rd_data),
    .best_score_o   (best_score),
    .runner_score_o (runner_score),
    .best_index_o   (best_idx)
  );

  assign out_valid_o        = out_valid_q;
  assign locked_o           = locked_q;
  assign second_of_minute_o = second_q;
  assign sync_position_o    = sync_pos_q;
  assign lock_margin_o      = margin_q;

endmodule

// ----- rtl/tsspl_checker.sv -----
`include "assert_macros.svh"

module tsspl_checker #(
  parameter int unsigned BIN_COUNT = tsspl_pkg::BIN_COUNT_DEF,
  parameter int unsigned IDX_W     = $clog2(BIN_COUNT)
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          locked_o,
  input logic [IDX_W-1:0]              second_of_minute_o,
  input logic [IDX_W-1:0]              sync_position_o
);

  localparam logic [IDX_W-1:0] IDX_END = IDX_W'(BIN_COUNT);

  // A stalled result stays offered
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // One tick at a time: a transfer closes the input until its result is loaded
  `ASSERT_NEXT(a_in_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // Without lock the second reads zero
  `ASSERT_IMPL(a_unlock_sec, clk_i, rst_ni, out_valid_o && !locked_o, second_of_minute_o == '0)

  // Reported positions stay inside the minute
  `ASSERT_IMPL(a_pos_range, clk_i, rst_ni, out_valid_o,
               (second_of_minute_o < IDX_END) && (sync_position_o < IDX_END))

endmodule

bind time_signal_second_phase_lock_core tsspl_checker #(
  .BIN_COUNT (BIN_COUNT),
  .IDX_W     (IDX_W)
) u_tsspl_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .locked_o           (locked_o),
  .second_of_minute_o (second_of_minute_o),
  .sync_position_o    (sync_position_o)
);
